// ===== rtl/imd_pkg.sv =====
// Shared types and constants for the IMU packet deframer.
package imd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [3:0] FIRST_POS  = 4'd2;
  localparam logic [3:0] LAST_DATA  = 4'd8;
  localparam logic [3:0] LAST_POS   = 4'd10;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/imd_front.sv =====
// Byte parser: header hunt, type decode, payload capture and packet push.
module imd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output imd_pkg::pkt_t      pkt
);

  imd_pkg::phase_t phase, phase_next;
  logic [3:0]      byte_position, byte_position_next;
  logic [1:0]      held_kind, held_kind_next;
  logic [7:0]      payload [6];
  logic            type_ok;
  logic            at_end;
  logic            store;
  logic [2:0]      slot;

  assign type_ok = (rx_byte == imd_pkg::TYPE_ACC) || (rx_byte == imd_pkg::TYPE_RATE)
                || (rx_byte == imd_pkg::TYPE_ANGLE);
  assign at_end  = (byte_position >= imd_pkg::LAST_POS);

  // next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      imd_pkg::PH_TYPE: begin
        if (type_ok) begin
          phase_next = imd_pkg::PH_DATA;
        end else if (rx_byte == imd_pkg::HDR_BYTE) begin
          phase_next = imd_pkg::PH_TYPE;
        end else begin
          phase_next = imd_pkg::PH_HUNT;
        end
      end
      imd_pkg::PH_DATA: begin
        if (at_end) begin
          phase_next = imd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = (rx_byte == imd_pkg::HDR_BYTE) ? imd_pkg::PH_TYPE : imd_pkg::PH_HUNT;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    byte_position_next = byte_position;
    held_kind_next     = held_kind;
    push               = 1'b0;
    store              = 1'b0;
    unique case (phase)
      imd_pkg::PH_TYPE: begin
        if (type_ok) begin
          held_kind_next     = rx_byte[1:0] - 2'd1;
          byte_position_next = imd_pkg::FIRST_POS;
        end
      end
      imd_pkg::PH_DATA: begin
        if (at_end) begin
          push               = fire;
          byte_position_next = 4'd0;
        end else begin
          store              = (byte_position >= imd_pkg::FIRST_POS)
                            && (byte_position < imd_pkg::LAST_DATA);
          byte_position_next = byte_position + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign slot = 3'(byte_position - imd_pkg::FIRST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= imd_pkg::PH_HUNT;
      byte_position <= 4'd0;
      held_kind     <= 2'd0;
    end else if (fire) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      held_kind     <= held_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store) begin
      payload[slot] <= rx_byte;
    end
  end

  assign pkt.kind = held_kind;
  assign pkt.x    = {payload[1], payload[0]};
  assign pkt.y    = {payload[3], payload[2]};
  assign pkt.z    = {payload[5], payload[4]};

endmodule

// ===== rtl/imd_queue.sv =====
// Two-entry packet queue between parser and output stage.
module imd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  imd_pkg::pkt_t      wr_pkt,
  input  logic               pop,
  output imd_pkg::pkt_t      rd_pkt,
  output imd_pkg::qstat_t    stat
);

  imd_pkg::pkt_t                   entry [imd_pkg::QDEPTH];
  logic [imd_pkg::QAW-1:0]         wr_ptr;
  logic [imd_pkg::QAW-1:0]         rd_ptr;
  logic [imd_pkg::QAW:0]           count;

  assign stat.full  = (count == (imd_pkg::QAW+1)'(imd_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign rd_pkt     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_pkt;
    end
  end

endmodule

// ===== rtl/imd_back.sv =====
// Output register stage: drains the queue onto the result channel.
module imd_back (
  input  logic               clk,
  input  logic               rst,
  input  imd_pkg::qstat_t    stat,
  input  imd_pkg::pkt_t      rd_pkt,
  output logic               pop,
  input  logic               pkt_ready,
  output logic               pkt_valid,
  output imd_pkg::pkt_t      hold
);

  // Load a new packet when the register is empty or its packet leaves now.
  assign pop = !stat.empty && (!pkt_valid || pkt_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (pop) begin
      pkt_valid <= 1'b1;
    end else if (pkt_ready) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= rd_pkt;
    end
  end

endmodule

// ===== rtl/imu_packet_deframer.sv =====
// Top level of the IMU packet deframer: parser, packet queue and output stage.
//
//  channel | handshake            | payload                              | direction
//  --------+----------------------+--------------------------------------+----------
//  rx      | rx_valid / rx_ready  | rx_byte[7:0]                         | in
//  pkt     | pkt_valid / pkt_ready| packet_kind[1:0], x/y/z_word[15:0]   | out
//
// One byte is taken per cycle while the queue is not full; the parser state register sets that rate.
// A packet enters the queue at the edge that takes its eleventh byte and moves on
// into the output register once that register is free; pkt_valid then rises.
// Reset clears parser state, queue pointers and the output valid flag; the
// payload bytes and queue entries hold no reset value.
// rx_ready drops only while the two-entry queue is full; a stall on pkt_ready
// does not block the parser until both queue entries are occupied.
module imu_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        pkt_valid,
  input  logic        pkt_ready,
  output logic [1:0]  packet_kind,
  output logic [15:0] x_word,
  output logic [15:0] y_word,
  output logic [15:0] z_word
);

  imd_pkg::qstat_t stat;
  imd_pkg::pkt_t   front_pkt;
  imd_pkg::pkt_t   head_pkt;
  imd_pkg::pkt_t   out_pkt;
  logic            fire;
  logic            push;
  logic            pop;

  // Take a byte whenever the queue has room for a packet it may complete.
  assign rx_ready = !stat.full;
  assign fire     = rx_valid && rx_ready;

  imd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_byte),
    .push    (push),
    .pkt     (front_pkt)
  );

  imd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_pkt (front_pkt),
    .pop    (pop),
    .rd_pkt (head_pkt),
    .stat   (stat)
  );

  imd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .rd_pkt    (head_pkt),
    .pop       (pop),
    .pkt_ready (pkt_ready),
    .pkt_valid (pkt_valid),
    .hold      (out_pkt)
  );

  // Words leave as raw counts; their scaling depends on the packet kind.
  assign packet_kind = out_pkt.kind;
  assign x_word      = out_pkt.x;
  assign y_word      = out_pkt.y;
  assign z_word      = out_pkt.z;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the IMU packet deframer: byte stream in, decoded packets out.
`timescale 1ns / 100ps

module testbench;
  import imd_pkg::*;

  localparam int unsigned STREAM_BYTES   = 1600;
  localparam int unsigned CALM_TAIL      = 200;   // final bytes sent with no idling at all
  localparam int unsigned WATCHDOG_LIMIT = 500;   // cycles with no transaction on either side
  localparam int unsigned DRAIN_CYCLES   = 8;     // queue plus output register, with margin

  // Shadow deframer plus the queue of packets it has predicted but not yet seen.
  class packet_scoreboard;
    phase_t      phase;
    logic [1:0]  kind;
    logic [3:0]  pos;
    logic [7:0]  data [6];
    pkt_t        pending [$];
    int unsigned errors;

    function new();
      phase  = PH_HUNT;
      kind   = 2'd0;
      pos    = 4'd0;
      errors = 0;
      foreach (data[i]) data[i] = 8'h00;
    endfunction

    // Advance the shadow parser by one accepted byte; queue a packet on the eleventh.
    function void note_byte(logic [7:0] b);
      logic [7:0] offset;
      pkt_t       pkt;
      case (phase)
        PH_TYPE: begin
          if (b == TYPE_ACC || b == TYPE_RATE || b == TYPE_ANGLE) begin
            offset = b - TYPE_ACC;
            kind   = offset[1:0];
            pos    = FIRST_POS;
            phase  = PH_DATA;
          end else if (b == HDR_BYTE) begin
            phase = PH_TYPE;                 // repeated header: still waiting for a type
          end else begin
            phase = PH_HUNT;                 // unknown type is not taken as a header
          end
        end
        PH_DATA: begin
          if (pos >= LAST_POS) begin
            pkt.kind = kind;
            pkt.x    = {data[1], data[0]};
            pkt.y    = {data[3], data[2]};
            pkt.z    = {data[5], data[4]};
            pending.push_back(pkt);
            phase = PH_HUNT;
            pos   = 4'd0;
          end else begin
            // temperature bytes fall through without being stored
            if (pos >= FIRST_POS && pos < LAST_DATA) data[pos - FIRST_POS] = b;
            pos = pos + 4'd1;
          end
        end
        default: phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered packet with the oldest prediction.
    function void check_packet(pkt_t got);
      pkt_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected packet, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("packet_kind", {14'd0, want.kind}, {14'd0, got.kind});
      check_field("x_word", want.x, got.x);
      check_field("y_word", want.y, got.y);
      check_field("z_word", want.z, got.z);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        pkt_valid;
  logic        pkt_ready = 1'b0;
  logic [1:0]  packet_kind;
  logic [15:0] x_word;
  logic [15:0] y_word;
  logic [15:0] z_word;

  // Directed payloads: six data bytes, two temperature bytes, one checksum byte.
  logic [7:0] byte_list_a [9] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80,
                                  8'h00, 8'h00, 8'h00};
  logic [7:0] byte_list_b [9] = '{8'hFF, 8'h7F, 8'h55, 8'h55, 8'h01, 8'h00,
                                  8'h55, 8'h55, 8'hAA};

  packet_scoreboard sb = new();

  int unsigned bytes_sent  = 0;
  int unsigned quiet_count = 0;
  bit          idle_enable = 1'b1;   // cleared for the final stretch of the run
  bit          calm        = 1'b0;   // short stretches with no source gaps

  imu_packet_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_byte     (rx_byte),
    .pkt_valid   (pkt_valid),
    .pkt_ready   (pkt_ready),
    .packet_kind (packet_kind),
    .x_word      (x_word),
    .y_word      (y_word),
    .z_word      (z_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the rising edge, before the block's registers move.
  // The watchdog counts cycles in which neither side completes a transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_valid && rx_ready) sb.note_byte(rx_byte);
      if (pkt_valid && pkt_ready)
        sb.check_packet(pkt_t'({packet_kind, x_word, y_word, z_word}));
      if ((rx_valid && rx_ready) || (pkt_valid && pkt_ready)) begin
        quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d packets outstanding", $time,
                 sb.pending.size());
        $display("testbench: FAIL");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  // Sink side: hold pkt_ready low in random bursts while idling is allowed.
  initial begin
    forever begin
      @(negedge clk);
      if (idle_enable && !rst && $urandom_range(0, 5) == 0) begin
        pkt_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      pkt_ready <= 1'b1;
    end
  end

  // Present one byte and hold it until the transaction completes. Enter and leave
  // on a falling edge; valid stays high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    if (idle_enable && !calm && $urandom_range(0, 6) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    @(negedge clk);
    bytes_sent++;
    if (bytes_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
    if (bytes_sent + CALM_TAIL >= STREAM_BYTES) idle_enable = 1'b0;
  endtask

  // Send a header, the given type byte and the nine remaining packet bytes at random.
  task automatic send_frame(input logic [7:0] type_b);
    send_byte(HDR_BYTE);
    send_byte(type_b);
    repeat (9) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return TYPE_ACC;
      1:       return TYPE_RATE;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  initial begin
    logic [7:0] noise;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unknown type just below the valid range.
    send_byte(HDR_BYTE);
    send_byte(8'h50);
    // Repeated header, then a rate packet with all-zero, all-one and sign-bit words.
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(TYPE_RATE);
    foreach (byte_list_a[i]) send_byte(byte_list_a[i]);
    // Angle packet whose data and temperature bytes carry header bytes, which must not resync.
    send_byte(HDR_BYTE);
    send_byte(TYPE_ANGLE);
    foreach (byte_list_b[i]) send_byte(byte_list_b[i]);

    // Random: mostly well-formed packets, the rest noise and broken frames.
    while (bytes_sent < STREAM_BYTES) begin
      case ($urandom_range(0, 9))
        0: begin
          // loose noise, biased towards header and type bytes
          repeat ($urandom_range(1, 6)) begin
            noise = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) noise = 8'($urandom_range(8'h50, 8'h56));
            send_byte(noise);
          end
        end
        1: begin
          // header followed by an unknown type
          send_byte(HDR_BYTE);
          do noise = 8'($urandom_range(0, 255));
          while (noise == TYPE_ACC || noise == TYPE_RATE || noise == TYPE_ANGLE ||
                 noise == HDR_BYTE);
          send_byte(noise);
        end
        2: begin
          // a run of headers before the type
          repeat ($urandom_range(2, 4)) send_byte(HDR_BYTE);
          send_byte(pick_type());
          repeat (9) send_byte(8'($urandom_range(0, 255)));
        end
        default: send_frame(pick_type());
      endcase
    end
    rx_valid <= 1'b0;

    // Drain: wait for every predicted packet, then let the pipeline settle.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d predicted packets never delivered", $time, sb.pending.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
